[rtl/gtpb_pkg.sv]
// Shared types and constants for the Gouraud triangle pixel blend block.
// No dependencies.
`timescale 1ns / 1ps

package gtpb_pkg;

	localparam int PIX_W      = 12;  // pixel coordinate port width
	localparam int RGBA_W     = 32;
	localparam int CH_W       = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int POS_W      = 24;  // stored position field width
	localparam int QB         = 17;  // Q1.16 weight bits, one per divider stage
	localparam int WPROD_W    = QB + CH_W;
	localparam int WSUM_W     = WPROD_W + 2;

	localparam logic [QB-1:0] W_ONE = QB'(32'h0001_0000);
	localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_V0_POS  = 3'd0,
		REG_V1_POS  = 3'd1,
		REG_V2_POS  = 3'd2,
		REG_V0_RGBA = 3'd3,
		REG_V1_RGBA = 3'd4,
		REG_V2_RGBA = 3'd5
	} reg_idx_t;

	// per-request sideband carried along with the arithmetic
	typedef struct packed {
		logic              cov;
		logic [RGBA_W-1:0] dest;
	} side_t;

endpackage

[rtl/gtpb_ifs.sv]
// Valid/ready channel interfaces for pixel requests and blended results.
// Depends on gtpb_pkg.
`timescale 1ns / 1ps

interface gtpb_pix_if;
	import gtpb_pkg::*;
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  pixel_x;
	logic [PIX_W-1:0]  pixel_y;
	logic [RGBA_W-1:0] dest_rgba;
	modport source (output valid, output pixel_x, output pixel_y, output dest_rgba,
		input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input dest_rgba,
		output ready);
endinterface

interface gtpb_res_if;
	import gtpb_pkg::*;
	logic              valid;
	logic              ready;
	logic              covered;
	logic [RGBA_W-1:0] result_rgba;
	modport source (output valid, output covered, output result_rgba, input ready);
	modport sink (input valid, input covered, input result_rgba, output ready);
endinterface

[rtl/gouraud_triangle_pixel_blend.sv]
// Gouraud triangle coverage test, barycentric color interpolation and
// alpha blend over the framebuffer color, one pixel request per clock unless the receiver stalls.
// Depends on gtpb_pkg, gtpb_ifs (channels) and gtpb_div.
//
// Use: write the three vertex positions and colors on the cfg port while no
// request is in flight, then stream pixel requests (x, y, framebuffer color)
// on the pixel channel. Each request yields one result: the coverage flag
// and either the blended color or the untouched framebuffer color.
// Throughput: one request per cycle while the receiver takes results, set by
// a fully pipelined datapath: 4 stages of edge functions, 17 stages of
// divider (one weight bit per stage, alpha and beta in parallel), 5 stages
// of interpolation and blend, the last being the output register.
// Reset clears the vertex registers and all pipeline valid bits; the block
// is ready as soon as reset is released.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and the pixel channel drops ready; bubbles inside keep moving up otherwise.
// Triangle setup registers the winding swap flag from a write, then the edge
// deltas and areas; a request accepted after the write sees the new values.
`timescale 1ns / 1ps

module gouraud_triangle_pixel_blend #(
	parameter int COORD_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gtpb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtpb_pkg::CFG_DATA_W-1:0] cfg_data,
	gtpb_pix_if.sink                        pixel,
	gtpb_res_if.source                      result
);
	import gtpb_pkg::*;

	localparam int PPW = 2 * COORD_BITS;                     // stored position
	localparam int PB  = (COORD_BITS < PIX_W) ? COORD_BITS : PIX_W;
	localparam int DW  = COORD_BITS + 2;                     // coordinate deltas
	localparam int EW  = 2 * DW;                             // edge functions

	// ---------------- configuration registers ----------------
	logic [PPW-1:0]    pos_q [3];
	logic [RGBA_W-1:0] col_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				pos_q[k] <= '0;
				col_q[k] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_V0_POS:  pos_q[0] <= PPW'(cfg_data[POS_W-1:0]);
				REG_V1_POS:  pos_q[1] <= PPW'(cfg_data[POS_W-1:0]);
				REG_V2_POS:  pos_q[2] <= PPW'(cfg_data[POS_W-1:0]);
				REG_V0_RGBA: col_q[0] <= cfg_data[RGBA_W-1:0];
				REG_V1_RGBA: col_q[1] <= cfg_data[RGBA_W-1:0];
				REG_V2_RGBA: col_q[2] <= cfg_data[RGBA_W-1:0];
				default: ;  // unmapped index: ignored
			endcase
		end
	end

	// ---------------- triangle setup ----------------
	logic signed [COORD_BITS-1:0] vx [3];
	logic signed [COORD_BITS-1:0] vy [3];
	logic signed [DW-1:0]         ar_dx1, ar_dy1, ar_dx2, ar_dy2;
	logic signed [EW-1:0]         area;
	logic                         swap_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			vx[k] = $signed(pos_q[k][COORD_BITS-1:0]);
			vy[k] = $signed(pos_q[k][PPW-1:COORD_BITS]);
		end
		ar_dx1 = DW'(vx[1]) - DW'(vx[0]);
		ar_dy1 = DW'(vy[1]) - DW'(vy[0]);
		ar_dx2 = DW'(vx[2]) - DW'(vx[0]);
		ar_dy2 = DW'(vy[2]) - DW'(vy[0]);
		area   = EW'(ar_dx1) * EW'(ar_dy2) - EW'(ar_dy1) * EW'(ar_dx2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else begin
			swap_q <= !area[EW-1] && (area != '0);
		end
	end

	// vertices after the winding fix: v1 and v2 trade places
	logic signed [COORD_BITS-1:0] sx [3];
	logic signed [COORD_BITS-1:0] sy [3];
	logic [RGBA_W-1:0]            sc [3];

	always_comb begin
		sx[0] = vx[0];
		sy[0] = vy[0];
		sc[0] = col_q[0];
		sx[1] = swap_q ? vx[2] : vx[1];
		sy[1] = swap_q ? vy[2] : vy[1];
		sc[1] = swap_q ? col_q[2] : col_q[1];
		sx[2] = swap_q ? vx[1] : vx[2];
		sy[2] = swap_q ? vy[1] : vy[2];
		sc[2] = swap_q ? col_q[1] : col_q[2];
	end

	// edge k runs from vertex (k+1)%3 to vertex (k+2)%3
	logic signed [DW-1:0] ex [3];
	logic signed [DW-1:0] ey [3];
	logic signed [DW-1:0] dbx [3];
	logic signed [DW-1:0] dby [3];
	logic signed [DW-1:0] dbx_q [3];
	logic signed [DW-1:0] dby_q [3];
	logic [RGBA_W-1:0]    scol_q [3];
	logic signed [EW-1:0] e_q [2];
	logic                 ezero_q [2];

	genvar k;
	generate
		for (k = 0; k < 3; k++) begin : g_edge
			localparam int KA = (k + 1) % 3;
			localparam int KB = (k + 2) % 3;
			assign ex[k]  = DW'(sx[KA]);
			assign ey[k]  = DW'(sy[KA]);
			assign dbx[k] = DW'(sx[KB]) - DW'(sx[KA]);
			assign dby[k] = DW'(sy[KB]) - DW'(sy[KA]);
			always_ff @(posedge clk) begin
				dbx_q[k]  <= dbx[k];
				dby_q[k]  <= dby[k];
				scol_q[k] <= sc[k];
			end
			// doubled area as seen from edge k's opposite vertex (alpha, beta)
			if (k < 2) begin : g_norm
				logic signed [DW-1:0] ox, oy;
				logic signed [EW-1:0] ev;
				assign ox = DW'(sx[k]) - ex[k];
				assign oy = DW'(sy[k]) - ey[k];
				assign ev = EW'(ox) * EW'(dby[k]) - EW'(oy) * EW'(dbx[k]);
				always_ff @(posedge clk) begin
					e_q[k]     <= ev;
					ezero_q[k] <= (ev == '0);
				end
			end
		end
	endgenerate

	// ---------------- pixel pipeline ----------------
	logic en;
	assign en           = !result.valid || result.ready;
	assign pixel.ready  = en;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [PB-1:0]        px_s1, py_s1;
	logic [RGBA_W-1:0]    dest_s1, dest_s2, dest_s3;
	logic signed [DW-1:0] dx_s2 [3];
	logic signed [DW-1:0] dy_s2 [3];
	logic signed [EW-1:0] pp_s3 [3];
	logic signed [EW-1:0] qq_s3 [3];
	logic signed [EW-1:0] w_s4 [3];
	side_t                side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= pixel.pixel_x[PB-1:0];
			py_s1   <= pixel.pixel_y[PB-1:0];
			dest_s1 <= pixel.dest_rgba;
			// s2: pixel minus edge start
			for (int j = 0; j < 3; j++) begin
				dx_s2[j] <= DW'($signed({1'b0, px_s1})) - ex[j];
				dy_s2[j] <= DW'($signed({1'b0, py_s1})) - ey[j];
			end
			dest_s2 <= dest_s1;
			// s3: cross product terms
			for (int j = 0; j < 3; j++) begin
				pp_s3[j] <= EW'(dx_s2[j]) * EW'(dby_q[j]);
				qq_s3[j] <= EW'(dy_s2[j]) * EW'(dbx_q[j]);
			end
			dest_s3 <= dest_s2;
			// s4: edge functions and coverage
			for (int j = 0; j < 3; j++) begin
				w_s4[j] <= pp_s3[j] - qq_s3[j];
			end
			side_s4.cov  <= ((pp_s3[0] - qq_s3[0]) >= 0) &&
			                ((pp_s3[1] - qq_s3[1]) >= 0) &&
			                ((pp_s3[2] - qq_s3[2]) >= 0);
			side_s4.dest <= dest_s3;
		end
	end

	// ---------------- weight division, s5..s21 ----------------
	logic [QB-1:0] qa, qb;

	gtpb_div #(.W(EW), .QBITS(QB)) u_div_alpha (
		.clk (clk),
		.en  (en),
		.num (w_s4[0]),
		.den (e_q[0]),
		.quo (qa)
	);

	gtpb_div #(.W(EW), .QBITS(QB)) u_div_beta (
		.clk (clk),
		.en  (en),
		.num (w_s4[1]),
		.den (e_q[1]),
		.quo (qb)
	);

	// sideband delay line matching the divider depth
	logic  dv_v_s    [QB];
	side_t dv_side_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QB; j++) dv_v_s[j] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= v_s4;
			for (int j = 1; j < QB; j++) dv_v_s[j] <= dv_v_s[j-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= side_s4;
			for (int j = 1; j < QB; j++) dv_side_s[j] <= dv_side_s[j-1];
		end
	end

	// ---------------- interpolation and blend, s22..s26 ----------------
	logic v_s22, v_s23, v_s24, v_s25, v_s26;
	side_t side_s22, side_s23, side_s24, side_s25;
	logic [QB-1:0]      wt_s22 [3];            // alpha, beta, gamma
	logic [WPROD_W-1:0] prod_s23 [4][3];
	logic [CH_W-1:0]    src_s24 [4];
	logic [CH_W-1:0]    sa_s25;
	logic signed [2*CH_W+1:0] dp_s25 [3];
	logic               cov_s26;
	logic [RGBA_W-1:0]  rgba_s26;

	logic [QB-1:0] al, be;
	assign al = ezero_q[0] ? '0 : qa;
	assign be = ezero_q[1] ? '0 : qb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
			v_s23 <= 1'b0;
			v_s24 <= 1'b0;
			v_s25 <= 1'b0;
			v_s26 <= 1'b0;
		end else if (en) begin
			v_s22 <= dv_v_s[QB-1];
			v_s23 <= v_s22;
			v_s24 <= v_s23;
			v_s25 <= v_s24;
			v_s26 <= v_s25;
		end
	end

	logic [WSUM_W-1:0] csum [4];
	logic [WSUM_W-17:0] cint [4];
	logic [CH_W:0]      dmag [3];
	logic [CH_W:0]      dq [3];
	logic [CH_W-1:0]    bl [3];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			csum[c] = WSUM_W'(prod_s23[c][0]) + WSUM_W'(prod_s23[c][1]) +
			          WSUM_W'(prod_s23[c][2]);
			cint[c] = csum[c][WSUM_W-1:16];
		end
		for (int c = 0; c < 3; c++) begin
			// |(s-d)*a| / 255 by the shift-add reciprocal, exact below 65535
			logic [2*CH_W+1:0] m;
			logic [2*CH_W+1:0] qv;
			m       = dp_s25[c][2*CH_W+1] ? (2*CH_W+2)'(-dp_s25[c]) : dp_s25[c];
			qv      = (m + (m >> 8) + 1'b1) >> 8;
			dq[c]   = qv[CH_W:0];
			dmag[c] = {1'b0, side_s25.dest[c*CH_W +: CH_W]};
			bl[c]   = dp_s25[c][2*CH_W+1] ? CH_W'(dmag[c] - dq[c]) :
			                                CH_W'(dmag[c] + dq[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s22: weights
			side_s22  <= dv_side_s[QB-1];
			wt_s22[0] <= al;
			wt_s22[1] <= be;
			wt_s22[2] <= W_ONE - al - be;
			// s23: weight times vertex channel
			side_s23 <= side_s22;
			for (int c = 0; c < 4; c++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s23[c][j] <= WPROD_W'(wt_s22[j]) *
					                  WPROD_W'(scol_q[j][c*CH_W +: CH_W]);
				end
			end
			// s24: sum, drop fraction, clamp
			side_s24 <= side_s23;
			for (int c = 0; c < 4; c++) begin
				src_s24[c] <= (cint[c] > (WSUM_W-16)'(CH_MAX)) ? CH_MAX :
				              cint[c][CH_W-1:0];
			end
			// s25: (src - dest) * src alpha
			side_s25 <= side_s24;
			sa_s25   <= src_s24[3];
			for (int c = 0; c < 3; c++) begin
				dp_s25[c] <= (2*CH_W+2)'($signed({1'b0, src_s24[c]}) -
				             $signed({1'b0, side_s24.dest[c*CH_W +: CH_W]})) *
				             (2*CH_W+2)'($signed({1'b0, src_s24[3]}));
			end
			// s26: output register
			cov_s26  <= side_s25.cov;
			rgba_s26 <= side_s25.cov ? {sa_s25, bl[2], bl[1], bl[0]} : side_s25.dest;
		end
	end

	assign result.valid       = v_s26;
	assign result.covered     = cov_s26;
	assign result.result_rgba = rgba_s26;

endmodule

[rtl/gtpb_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(num * 2^(QBITS-1) / den) for num <= den. No package use.
`timescale 1ns / 1ps

module gtpb_div #(
	parameter int W     = 28,
	parameter int QBITS = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [W-1:0]     num,
	input  logic [W-1:0]     den,
	output logic [QBITS-1:0] quo
);

	logic [W-1:0]     r_s [QBITS-1];
	logic [QBITS-1:0] q_s [QBITS];

	genvar i;
	generate
		for (i = 0; i < QBITS; i++) begin : g_stage
			logic [W-1:0] t;
			logic         ge;
			if (i == 0) begin : g_first
				assign t = num;
			end else begin : g_next
				// remainder stays below den, so the shift cannot overflow
				assign t = {r_s[i-1][W-2:0], 1'b0};
			end
			assign ge = (t >= den);

			if (i < QBITS - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						r_s[i] <= ge ? (t - den) : t;
					end
				end
			end

			if (i == 0) begin : g_q0
				always_ff @(posedge clk) begin
					if (en) begin
						q_s[i] <= QBITS'(ge);
					end
				end
			end else begin : g_qn
				always_ff @(posedge clk) begin
					if (en) begin
						q_s[i] <= {q_s[i-1][QBITS-2:0], ge};
					end
				end
			end
		end
	endgenerate

	assign quo = q_s[QBITS-1];

endmodule

[rtl/gtpb_chk.sv]
// Port-level checker for the triangle pixel blend block, bound to the top.
// Depends on gtpb_pkg and gouraud_triangle_pixel_blend.
`timescale 1ns / 1ps

module gtpb_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_covered,
	input logic [gtpb_pkg::RGBA_W-1:0] out_result
);
	import gtpb_pkg::*;

	// requests in flight
	logic [7:0] cnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 8'(in_valid && in_ready) - 8'(out_valid && out_ready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_result) &&
		$stable(out_covered))
		else $error("stalled result changed");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken while pipeline frozen");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready low with empty output");

	a_nogen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0)
		else $error("result without request");

endmodule

bind gouraud_triangle_pixel_blend gtpb_chk u_gtpb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pixel.valid),
	.in_ready    (pixel.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_covered (result.covered),
	.out_result  (result.result_rgba)
);

[tb/gtpb_checker.sv]
// Scoreboard for the Gouraud triangle pixel blend block: mirrors the vertex
// registers, predicts each pixel result and compares it with the block's output.
// Depends on gtpb_pkg and gtpb_ifs.
`timescale 1ns / 1ps

module gtpb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [gtpb_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [gtpb_pkg::CFG_DATA_W-1:0] cfg_data,
	gtpb_pix_if                             pixel,
	gtpb_res_if                             result,
	output int                              fail_count,
	output int                              pending,
	output int                              shaded_count,
	output int                              result_count
);
	import gtpb_pkg::*;

	typedef struct {
		logic              cov;
		logic [RGBA_W-1:0] rgba;
	} shade_t;

	logic [POS_W-1:0]  pos_v0, pos_v1, pos_v2;
	logic [RGBA_W-1:0] col_v0, col_v1, col_v2;
	shade_t            shade_q[$];

	function automatic longint coord(input logic [11:0] raw);
		return longint'($signed(raw));
	endfunction

	function automatic longint edge_val(input longint ax, ay, bx, by, px, py);
		return (px - ax) * (by - ay) - (py - ay) * (bx - ax);
	endfunction

	function automatic logic [7:0] lerp_chan(input longint wa, wb, wc,
			input logic [7:0] ca, cb, cc);
		longint s;
		s = wa * longint'(ca) + wb * longint'(cb) + wc * longint'(cc);
		if (s < 0)
			return 8'd0;
		s = s >>> 16;
		if (s > 255)
			return 8'hFF;
		return s[7:0];
	endfunction

	function automatic logic [7:0] mix_chan(input logic [7:0] d, s, a);
		int r;
		r = int'(d) + (int'(s) - int'(d)) * int'(a) / 255;
		return r[7:0];
	endfunction

	function automatic shade_t shade_pixel(input logic [PIX_W-1:0] x, y,
			input logic [RGBA_W-1:0] dest);
		shade_t o;
		longint px, py, x0, y0, x1, y1, x2, y2, t, w0, w1, w2, e0, e1, al, be, ga;
		logic [RGBA_W-1:0] c1, c2, tc;
		logic [7:0] sr, sg, sb, sa;
		px = longint'(x);
		py = longint'(y);
		x0 = coord(pos_v0[11:0]); y0 = coord(pos_v0[23:12]);
		x1 = coord(pos_v1[11:0]); y1 = coord(pos_v1[23:12]);
		x2 = coord(pos_v2[11:0]); y2 = coord(pos_v2[23:12]);
		c1 = col_v1;
		c2 = col_v2;
		// wind so the area is never positive
		if ((x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0) > 0) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
			tc = c1; c1 = c2; c2 = tc;
		end
		w0 = edge_val(x1, y1, x2, y2, px, py);
		w1 = edge_val(x2, y2, x0, y0, px, py);
		w2 = edge_val(x0, y0, x1, y1, px, py);
		o.cov = (w0 >= 0) && (w1 >= 0) && (w2 >= 0);
		o.rgba = dest;
		if (!o.cov)
			return o;
		e0 = edge_val(x1, y1, x2, y2, x0, y0);
		e1 = edge_val(x2, y2, x0, y0, x1, y1);
		al = (e0 == 0) ? 0 : (w0 * 65536) / e0;
		be = (e1 == 0) ? 0 : (w1 * 65536) / e1;
		ga = 65536 - al - be;
		sr = lerp_chan(al, be, ga, col_v0[7:0], c1[7:0], c2[7:0]);
		sg = lerp_chan(al, be, ga, col_v0[15:8], c1[15:8], c2[15:8]);
		sb = lerp_chan(al, be, ga, col_v0[23:16], c1[23:16], c2[23:16]);
		sa = lerp_chan(al, be, ga, col_v0[31:24], c1[31:24], c2[31:24]);
		o.rgba = {sa, mix_chan(dest[23:16], sb, sa), mix_chan(dest[15:8], sg, sa),
			mix_chan(dest[7:0], sr, sa)};
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shade_t want;
		if (!arst_n) begin
			pos_v0 <= '0; pos_v1 <= '0; pos_v2 <= '0;
			col_v0 <= '0; col_v1 <= '0; col_v2 <= '0;
			shade_q.delete();
			fail_count <= 0;
			shaded_count <= 0;
			result_count <= 0;
		end else begin
			if (pixel.valid && pixel.ready)
				shade_q.push_back(shade_pixel(pixel.pixel_x, pixel.pixel_y,
					pixel.dest_rgba));
			if (result.valid && result.ready) begin
				result_count <= result_count + 1;
				if (result.covered)
					shaded_count <= shaded_count + 1;
				if (shade_q.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: unexpected result covered=%b rgba=%08h", $time,
						result.covered, result.result_rgba);
				end else begin
					want = shade_q.pop_front();
					if (want.cov !== result.covered || want.rgba !== result.result_rgba) begin
						fail_count <= fail_count + 1;
						if (fail_count < 30)
							$display("%0t: mismatch expected covered=%b rgba=%08h, got covered=%b rgba=%08h",
								$time, want.cov, want.rgba, result.covered, result.result_rgba);
					end
				end
			end
			if (cfg_we)
				case (cfg_idx)
					REG_V0_POS:  pos_v0 <= cfg_data[POS_W-1:0];
					REG_V1_POS:  pos_v1 <= cfg_data[POS_W-1:0];
					REG_V2_POS:  pos_v2 <= cfg_data[POS_W-1:0];
					REG_V0_RGBA: col_v0 <= cfg_data;
					REG_V1_RGBA: col_v1 <= cfg_data;
					REG_V2_RGBA: col_v2 <= cfg_data;
					default: ;
				endcase
		end
		pending = shade_q.size();
	end

endmodule

[tb/tb.sv]
// Top of the pixel blend regression: clock, reset, triangle setup and pixel
// stimulus, result back-pressure, verdict. Depends on gtpb_pkg, gtpb_ifs,
// gtpb_checker and the block itself.
`timescale 1ns / 1ps

module tb;
	import gtpb_pkg::*;

	// indexes past the last register; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam int PIPE_DRAIN = 40;       // comfortably past the pipeline latency
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int fail_count, pending, shaded_count, result_count;
	int cycles = 0;
	bit full_rate = 1'b0;     // phase with no gaps and no stalls
	int ready_hold = 0;

	// triangle currently loaded, kept to aim pixels at its bounding box
	int tri_x[3], tri_y[3];

	gtpb_pix_if pix_ch();
	gtpb_res_if res_ch();

	gouraud_triangle_pixel_blend DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .pixel(pix_ch), .result(res_ch)
	);

	gtpb_checker scoreboard (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .pixel(pix_ch), .result(res_ch),
		.fail_count(fail_count), .pending(pending),
		.shaded_count(shaded_count), .result_count(result_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// result back-pressure: runs of ready or stall of random length
	always @(negedge clk) begin
		if (!arst_n || full_rate)
			res_ch.ready <= 1'b1;
		else if (ready_hold > 0)
			ready_hold <= ready_hold - 1;
		else begin
			res_ch.ready <= ($urandom_range(0, 3) != 0);
			ready_hold <= gap_len();
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		pix_ch.dest_rgba = '0;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = data;
	endtask

	function automatic logic [31:0] pack_pos(input int x, input int y);
		logic [11:0] xs, ys;
		xs = x[11:0];
		ys = y[11:0];
		return {8'h00, ys, xs};
	endfunction

	// Load a whole triangle. Called only with nothing in flight.
	task automatic load_triangle(input int x0, y0, x1, y1, x2, y2,
			input logic [31:0] c0, c1, c2);
		wait (pending == 0);
		repeat (4) @(negedge clk);
		tri_x[0] = x0; tri_y[0] = y0;
		tri_x[1] = x1; tri_y[1] = y1;
		tri_x[2] = x2; tri_y[2] = y2;
		write_reg(REG_V0_POS, pack_pos(x0, y0));
		write_reg(REG_V1_POS, pack_pos(x1, y1));
		write_reg(REG_V2_POS, pack_pos(x2, y2));
		write_reg(REG_V0_RGBA, c0);
		write_reg(REG_V1_RGBA, c1);
		write_reg(REG_V2_RGBA, c2);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// One pixel request; holds it until the block takes it.
	task automatic send_pixel(input logic [11:0] x, y, input logic [31:0] dest);
		int gap;
		gap = full_rate ? 0 : gap_len();
		if (gap > 0) begin
			pix_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.pixel_x = x;
		pix_ch.pixel_y = y;
		pix_ch.dest_rgba = dest;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		@(negedge clk);
	endtask

	task automatic idle_pixels();
		pix_ch.valid = 1'b0;
	endtask

	function automatic int clamp_pix(input int v);
		if (v < 0) return 0;
		if (v > 4095) return 4095;
		return v;
	endfunction

	// random pixel, mostly inside the triangle's bounding box
	task automatic send_random_pixel();
		int lx, hx, ly, hy;
		logic [31:0] dest;
		dest = $urandom();
		if ($urandom_range(0, 9) == 0)
			dest = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
		if ($urandom_range(0, 4) == 0) begin
			send_pixel(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)), dest);
		end else begin
			lx = clamp_pix(tri_x[0] < tri_x[1] ? (tri_x[0] < tri_x[2] ? tri_x[0] : tri_x[2])
				: (tri_x[1] < tri_x[2] ? tri_x[1] : tri_x[2]));
			hx = clamp_pix(tri_x[0] > tri_x[1] ? (tri_x[0] > tri_x[2] ? tri_x[0] : tri_x[2])
				: (tri_x[1] > tri_x[2] ? tri_x[1] : tri_x[2]));
			ly = clamp_pix(tri_y[0] < tri_y[1] ? (tri_y[0] < tri_y[2] ? tri_y[0] : tri_y[2])
				: (tri_y[1] < tri_y[2] ? tri_y[1] : tri_y[2]));
			hy = clamp_pix(tri_y[0] > tri_y[1] ? (tri_y[0] > tri_y[2] ? tri_y[0] : tri_y[2])
				: (tri_y[1] > tri_y[2] ? tri_y[1] : tri_y[2]));
			send_pixel(12'($urandom_range(lx, hx)), 12'($urandom_range(ly, hy)), dest);
		end
	endtask

	function automatic logic [31:0] random_color();
		case ($urandom_range(0, 5))
			0: return 32'hFFFF_FFFF;
			1: return 32'h0000_0000;
			2: return {8'hFF, 24'($urandom())};
			default: return $urandom();
		endcase
	endfunction

	initial begin
		int kind, a, b;
		int s[6];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset values: every vertex at the origin, degenerate, every pixel
		// lies on the "line" and takes vertex 2's transparent black.
		tri_x = '{0, 0, 0}; tri_y = '{0, 0, 0};
		@(negedge clk);
		send_pixel(12'd0, 12'd0, 32'h1234_5678);
		send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
		send_pixel(12'd0, 12'hFFF, 32'h0);
		idle_pixels();

		// Positive area, so the block must swap v1 and v2.
		load_triangle(10, 10, 200, 20, 50, 220, 32'hFF00_00FF, 32'hC000_FF00, 32'h40FF_0000);
		send_pixel(12'd10, 12'd10, 32'hFFFF_FFFF);
		send_pixel(12'd200, 12'd20, 32'h0);
		send_pixel(12'd50, 12'd220, 32'h8080_8080);
		send_pixel(12'd86, 12'd83, 32'h0102_0304);
		send_pixel(12'd105, 12'd15, 32'hA5A5_A5A5);
		send_pixel(12'hFFF, 12'd0, 32'h5A5A_5A5A);
		send_pixel(12'd0, 12'hFFF, 32'hFFFF_FFFF);
		idle_pixels();

		// Same triangle with the other winding, half-transparent.
		load_triangle(10, 10, 50, 220, 200, 20, 32'h80FF_FFFF, 32'h8000_0000, 32'h8012_3456);
		send_pixel(12'd86, 12'd83, 32'hFFFF_FFFF);
		send_pixel(12'd60, 12'd100, 32'h0);
		idle_pixels();

		// Collinear vertices: zero divisors.
		load_triangle(0, 0, 100, 100, 50, 50, 32'hFFFF_FFFF, 32'hFF00_0000, 32'hFF33_6699);
		send_pixel(12'd25, 12'd25, 32'h0);
		send_pixel(12'd100, 12'd100, 32'hFFFF_FFFF);
		send_pixel(12'd25, 12'd26, 32'hDEAD_BEEF);
		idle_pixels();

		// Extreme coordinates; stray upper bits and spare indexes are dropped.
		load_triangle(2047, 2047, -2048, -2048, 2047, -2048,
			32'hFFFF_FFFF, 32'h0, 32'h8080_8080);
		wait (pending == 0);
		write_reg(REG_V0_POS, 32'hFF7F_F7FF);
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
		@(negedge clk);
		cfg_we = 1'b0;
		send_pixel(12'd0, 12'd0, 32'h0);
		send_pixel(12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
		send_pixel(12'd2047, 12'd0, 32'h7F7F_7F7F);
		send_pixel(12'd1000, 12'd2047, 32'h0);
		idle_pixels();

		// Random triangles, about 160 pixels each. Vertices stay inside the
		// signed coordinate range so the bounding box matches the triangle.
		for (int ph = 0; ph < 12; ph++) begin
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				a = $urandom_range(0, 1600);
				b = $urandom_range(0, 1600);
				foreach (s[i])
					s[i] = (i % 2 ? b : a) + $urandom_range(0, 400);
			end else if (kind == 6) begin
				foreach (s[i])
					s[i] = $urandom_range(0, 4095) - 2048;
			end else if (kind == 7) begin
				s[0] = $urandom_range(0, 1000); s[1] = $urandom_range(0, 1000);
				s[2] = s[0] + 200; s[3] = s[1] + 100;
				s[4] = s[0] + 100; s[5] = s[1] + 50;
			end else begin
				foreach (s[i])
					s[i] = $urandom_range(0, 400) - 100;
			end
			load_triangle(s[0], s[1], s[2], s[3], s[4], s[5],
				random_color(), random_color(), random_color());
			full_rate = (ph % 4 == 3);
			repeat (160) send_random_pixel();
			idle_pixels();
			full_rate = 1'b0;
		end

		wait (pending == 0);
		repeat (PIPE_DRAIN) @(posedge clk);
		$display("%0d pixel results checked, %0d of them inside the triangle;", result_count,
			shaded_count);
		$display("reset, swapped, degenerate, extreme and random triangles under back-pressure.");
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
